### sv/tdpq_pkg.sv
`default_nettype none

package tdpq_pkg;

  localparam int TAG_W   = 8;
  localparam int FLOOR_W = 7;
  localparam int DIST_W  = 7;
  localparam int OCC_W   = 6;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DIST_W-1:0]  travel_dist;
    logic [TAG_W-1:0]   tag;
    logic [FLOOR_W-1:0] start_floor;
    logic [FLOOR_W-1:0] end_floor;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

### sv/tdpq_ctrl.sv
`default_nettype none

module tdpq_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output tdpq_pkg::cmd_t   cmd
);

  tdpq_pkg::state_t state_r;
  tdpq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdpq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    case (state_r)
      tdpq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = tdpq_pkg::ST_EXEC;
        end
      end
      tdpq_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = tdpq_pkg::ST_DONE;
      end
      tdpq_pkg::ST_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = tdpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdpq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/tdpq_datapath.sv
`default_nettype none

module tdpq_datapath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tdpq_pkg::cmd_t                      cmd,
  input  wire logic [tdpq_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                                in_tuser,
  output logic [tdpq_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [tdpq_pkg::OUT_TUSER_W-1:0]         out_tuser
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                            op_r;
  logic [tdpq_pkg::TAG_W-1:0]      tag_r;
  logic [tdpq_pkg::FLOOR_W-1:0]    sf_r;
  logic [tdpq_pkg::FLOOR_W-1:0]    ef_r;

  tdpq_pkg::entry_t                entries_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                count_nxt;

  logic [tdpq_pkg::OUT_TDATA_W-1:0] tdata_r;
  logic [tdpq_pkg::OUT_TDATA_W-1:0] tdata_nxt;
  logic [tdpq_pkg::OUT_TUSER_W-1:0] tuser_r;
  logic [tdpq_pkg::OUT_TUSER_W-1:0] tuser_nxt;

  logic [tdpq_pkg::DIST_W-1:0]     new_dist;
  tdpq_pkg::entry_t                new_entry;
  logic                            full;
  logic                            empty;
  logic                            do_insert;
  logic                            do_pop;
  logic [QUEUE_DEPTH-1:0]          ins_here;

  // input word register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tuser;
      tag_r <= in_tdata[7:0];
      sf_r  <= in_tdata[14:8];
      ef_r  <= in_tdata[21:15];
    end
  end

  assign new_dist = (sf_r >= ef_r) ? (sf_r - ef_r) : (ef_r - sf_r);

  always_comb begin
    new_entry.travel_dist = new_dist;
    new_entry.tag         = tag_r;
    new_entry.start_floor = sf_r;
    new_entry.end_floor   = ef_r;
  end

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_insert = cmd.exec && (op_r == tdpq_pkg::OP_INSERT) && !full;
  assign do_pop    = cmd.exec && (op_r == tdpq_pkg::OP_POP) && !empty;

  // compare-and-shift cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign ins_here[i] = (CNT_W'(i) >= count_r) || (new_dist > entries_r[i].travel_dist);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_insert && ins_here[0]) begin
          entries_r[0] <= new_entry;
        end else if (do_pop && (QUEUE_DEPTH > 1)) begin
          entries_r[0] <= entries_r[1];
        end
      end
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (ins_here[i-1]) begin
            entries_r[i] <= entries_r[i-1];
          end else if (ins_here[i]) begin
            entries_r[i] <= new_entry;
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (ins_here[i-1]) begin
            entries_r[i] <= entries_r[i-1];
          end else if (ins_here[i]) begin
            entries_r[i] <= new_entry;
          end
        end else if (do_pop) begin
          entries_r[i] <= entries_r[i+1];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    tdata_nxt = tdata_r;
    tuser_nxt = tuser_r;
    if (cmd.exec) begin
      tuser_nxt = '0;
      if (do_insert) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (do_pop) begin
        count_nxt = count_r - CNT_W'(1);
      end
      if (op_r == tdpq_pkg::OP_INSERT) begin
        tuser_nxt[1] = full;
        tdata_nxt    = {4'b0, tdpq_pkg::OCC_W'(count_nxt), 22'b0};
      end else if (!empty) begin
        tuser_nxt[0] = 1'b1;
        tdata_nxt    = {4'b0, tdpq_pkg::OCC_W'(count_nxt), entries_r[0].end_floor,
                        entries_r[0].start_floor, entries_r[0].tag};
      end else begin
        tdata_nxt    = {4'b0, tdpq_pkg::OCC_W'(count_nxt), 22'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tdata_r <= tdata_nxt;
    tuser_r <= tuser_nxt;
  end

  assign out_tdata = tdata_r;
  assign out_tuser = tuser_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(count_r))
    else $error("entry count moved outside execute");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (op_r == tdpq_pkg::OP_INSERT) && full |=> tuser_r[1] && $stable(count_r))
    else $error("full insert not dropped");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (count_r == $past(count_r) - CNT_W'(1)) && tuser_r[0])
    else $error("pop did not remove head");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (entries_r[0].travel_dist >= entries_r[1].travel_dist))
    else $error("head entry out of order");

endmodule

`default_nettype wire

### sv/travel_distance_priority_queue.sv
// bounded priority queue of ride requests, ordered by travel distance
// |start_floor - end_floor| with the longest ride first and equal distances
// kept in arrival order. tuser on the input selects insert (0) or pop (1).
// every word yields exactly one result word: a pop returns the head entry
// with result_valid set, an empty pop returns zeros, an insert into a full
// queue is dropped with dropped_full set; occupancy is the count after the
// operation, low 6 bits. one word is handled at a time: one state takes the
// word, one in which every cell of the QUEUE_DEPTH-entry compare-and-shift
// row compares against the new distance and shifts in parallel, and one
// presents the result and holds it through any output stall.
// no clearing pass is needed after reset.
`default_nettype none

module travel_distance_priority_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // request_tag, start_floor, end_floor, 2'b0
  input  wire logic        in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_tag, out_start_floor, out_end_floor, occupancy, 4'b0
  output logic [1:0]       out_tuser   // result_valid, dropped_full
);

  tdpq_pkg::cmd_t cmd;

  tdpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tdpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

### verif/travel_distance_priority_queue_tb.sv
`default_nettype none

module travel_distance_priority_queue_tb;

  localparam int   TAG_W     = tdpq_pkg::TAG_W;
  localparam int   FLOOR_W   = tdpq_pkg::FLOOR_W;
  localparam int   DIST_W    = tdpq_pkg::DIST_W;
  localparam int   OCC_W     = tdpq_pkg::OCC_W;
  localparam logic OP_INSERT = tdpq_pkg::OP_INSERT;
  localparam logic OP_POP    = tdpq_pkg::OP_POP;

  localparam int DEPTH        = 32;
  localparam int RANDOM_WORDS = 750;
  localparam int QUIET_WORDS  = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 200;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic               valid;
    logic               dropped;
    logic [TAG_W-1:0]   tag;
    logic [FLOOR_W-1:0] start_floor;
    logic [FLOOR_W-1:0] end_floor;
    logic [OCC_W-1:0]   occ;
  } ride_result_t;

  typedef struct packed {
    logic               op;
    logic [TAG_W-1:0]   tag;
    logic [FLOOR_W-1:0] start_floor;
    logic [FLOOR_W-1:0] end_floor;
    logic               typed;
    ride_result_t       res;
  } ride_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  localparam int DIRECTED_ROWS = 18;
  localparam ride_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b1, '{1'b0, 1'b0, 8'd0,   7'd0,   7'd0,   6'd0}},
    '{OP_INSERT, 8'd0,    7'd0,    7'd0,    1'b1, '{1'b0, 1'b0, 8'd0,   7'd0,   7'd0,   6'd1}},
    '{OP_INSERT, 8'd255,  7'd127,  7'd0,    1'b1, '{1'b0, 1'b0, 8'd0,   7'd0,   7'd0,   6'd2}},
    '{OP_INSERT, 8'd1,    7'd0,    7'd127,  1'b1, '{1'b0, 1'b0, 8'd0,   7'd0,   7'd0,   6'd3}},
    '{OP_INSERT, 8'd2,    7'd10,   7'd20,   1'b0, '0},
    '{OP_INSERT, 8'd3,    7'd20,   7'd10,   1'b0, '0},
    '{OP_INSERT, 8'd4,    7'd5,    7'd5,    1'b0, '0},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b1, '{1'b1, 1'b0, 8'd255, 7'd127, 7'd0,   6'd5}},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b1, '{1'b1, 1'b0, 8'd1,   7'd0,   7'd127, 6'd4}},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b0, '0},
    '{OP_INSERT, 8'hAA,   7'h55,   7'h2A,   1'b0, '0},
    '{OP_INSERT, 8'h55,   7'h2A,   7'h55,   1'b0, '0},
    '{OP_POP,    8'hFF,   7'h7F,   7'h7F,   1'b0, '0},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b0, '0},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b0, '0},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b0, '0},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b0, '0},
    '{OP_POP,    8'd0,    7'd0,    7'd0,    1'b1, '{1'b0, 1'b0, 8'd0,   7'd0,   7'd0,   6'd0}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  tdpq_pkg::entry_t held_rides[$];
  ride_result_t     rides_due[$];
  int               words_sent = 0;
  int               mismatches = 0;
  int               cycle_count = 0;
  bit               quiet = 1'b0;

  travel_distance_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic ride_result_t rank_ride(logic op, logic [TAG_W-1:0] tag,
                                             logic [FLOOR_W-1:0] sf,
                                             logic [FLOOR_W-1:0] ef);
    ride_result_t     r;
    tdpq_pkg::entry_t e;
    int               pos;
    r = '0;
    if (op == OP_INSERT) begin
      if (held_rides.size() >= DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        e.travel_dist = (sf >= ef) ? DIST_W'(sf - ef) : DIST_W'(ef - sf);
        e.tag         = tag;
        e.start_floor = sf;
        e.end_floor   = ef;
        pos = held_rides.size();
        for (int i = 0; i < held_rides.size(); i++) begin
          if (e.travel_dist > held_rides[i].travel_dist) begin
            pos = i;
            break;
          end
        end
        held_rides.insert(pos, e);
      end
    end else if (held_rides.size() > 0) begin
      e = held_rides.pop_front();
      r.valid       = 1'b1;
      r.tag         = e.tag;
      r.start_floor = e.start_floor;
      r.end_floor   = e.end_floor;
    end
    r.occ = OCC_W'(held_rides.size());
    return r;
  endfunction

  task automatic offer_ride(input logic op, input logic [TAG_W-1:0] tag,
                            input logic [FLOOR_W-1:0] sf, input logic [FLOOR_W-1:0] ef,
                            input logic typed, input ride_result_t typed_res);
    ride_result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, ef, sf, tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = rank_ride(op, tag, sf, ef);
    rides_due.push_back(typed ? typed_res : r);
    words_sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic logic [FLOOR_W-1:0] pick_floor();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd127;
      2, 3:    return FLOOR_W'($urandom_range(0, 7));
      default: return FLOOR_W'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    mix_t         mix;
    logic         op;
    int           insert_pct;
    ride_result_t none;
    none       = '0;
    mix        = MIX_FILL;
    insert_pct = 85;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_INSERT;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i]) begin
      offer_ride(DIRECTED[i].op, DIRECTED[i].tag, DIRECTED[i].start_floor,
                 DIRECTED[i].end_floor, DIRECTED[i].typed, DIRECTED[i].res);
      sender_gap();
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0 && n != 0) begin
        case ($urandom_range(0, 2))
          0:       mix = MIX_FILL;
          1:       mix = MIX_DRAIN;
          default: mix = MIX_EVEN;
        endcase
      end
      case (mix)
        MIX_FILL:  insert_pct = 85;
        MIX_DRAIN: insert_pct = 15;
        default:   insert_pct = 50;
      endcase
      quiet = (n >= RANDOM_WORDS - QUIET_WORDS);
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
      offer_ride(op, TAG_W'($urandom_range(0, 255)), pick_floor(), pick_floor(), 1'b0, none);
      sender_gap();
    end
    in_tvalid <= 1'b0;
    while (rides_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("travel_distance_priority_queue_tb OK");
    end else begin
      $display("travel_distance_priority_queue_tb NOT OK");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the queue up
  initial begin
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ride_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rides_due.size() == 0) begin
        $error("result word with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = rides_due.pop_front();
        if (out_tuser[0] !== want.valid) begin
          $error("result_valid expected %0d got %0d", want.valid, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.dropped) begin
          $error("dropped_full expected %0d got %0d", want.dropped, out_tuser[1]);
          mismatches++;
        end
        if (out_tdata[7:0] !== want.tag) begin
          $error("out_tag expected %0d got %0d", want.tag, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[14:8] !== want.start_floor) begin
          $error("out_start_floor expected %0d got %0d", want.start_floor, out_tdata[14:8]);
          mismatches++;
        end
        if (out_tdata[21:15] !== want.end_floor) begin
          $error("out_end_floor expected %0d got %0d", want.end_floor, out_tdata[21:15]);
          mismatches++;
        end
        if (out_tdata[27:22] !== want.occ) begin
          $error("occupancy expected %0d got %0d", want.occ, out_tdata[27:22]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("travel_distance_priority_queue_tb NOT OK");
      $finish;
    end
  end

endmodule

`default_nettype wire

### files.f
sv/tdpq_pkg.sv
sv/tdpq_ctrl.sv
sv/tdpq_datapath.sv
sv/travel_distance_priority_queue.sv
verif/travel_distance_priority_queue_tb.sv
